// ===== design/tdd_pkg.sv =====
package tdd_pkg;
   localparam int unsigned TGT_W  = 256;
   localparam int unsigned REM_W  = TGT_W + 1;
   localparam int unsigned SIG_W  = 53;
   localparam int unsigned FRAC_W = 52;
   localparam int unsigned EXP_W  = 11;
   localparam int unsigned SH_W   = 8;

   // numerator 0xffff * 2^208 with its leading one moved up to bit 255
   localparam logic [TGT_W-1:0] NUM_NORM = {16'hffff, 240'b0};
   localparam logic [63:0]      DBL_INF  = 64'h7FF0_0000_0000_0000;
   // exponent bias folded with the 224 - 256 offset, less one for the hidden bit the significand adds
   localparam logic [EXP_W-1:0] EXP_BASE = 11'd990;

   typedef struct packed {
      logic ge;
      logic eq;
   } cmp_type;
endpackage

// ===== design/tdd_div_step.sv =====
module tdd_div_step
   import tdd_pkg::*;
(
   input  logic [REM_W-1:0] rem,
   input  logic [TGT_W-1:0] den,
   output cmp_type          cmp,
   output logic [REM_W-1:0] rem_next
);
   logic [REM_W-1:0] diff;

   // one restoring step: trial subtract, keep on no borrow, shift left
   always_comb begin
      diff     = rem - {1'b0, den};
      cmp.ge   = (rem >= {1'b0, den});
      cmp.eq   = (rem == {1'b0, den});
      rem_next = cmp.ge ? {diff[REM_W-2:0], 1'b0} : {rem[REM_W-2:0], 1'b0};
   end
endmodule

// ===== design/target_to_difficulty_double_unit.sv =====
// Channel   | Ports                                         | Handshake
// request   | req_cmd, req_target_word_0..3, req_compact_bits | start & !busy
// response  | rsp_difficulty_bits, rsp_target_was_zero        | rsp_valid, 1 cycle
//
// A beat runs from accept through binary normalization of the target, the
// exponent compare, the 53 quotient bits from the shared 257-bit
// subtract/compare (one quotient bit each), and rounding, then the strobe.
// A zero target skips normalization and division and returns infinity.
// busy is high until the strobe, so the next beat can be taken at the edge
// that ends the strobe.
// Reset is synchronous and clears the sequencer and the strobe.
// The receiver cannot stall; the result is shown for exactly one cycle.
module target_to_difficulty_double_unit
   import tdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [63:0] req_target_word_0,
   input  logic [63:0] req_target_word_1,
   input  logic [63:0] req_target_word_2,
   input  logic [63:0] req_target_word_3,
   input  logic [31:0] req_compact_bits,
   output logic        rsp_valid,
   output logic [63:0] rsp_difficulty_bits,
   output logic        rsp_target_was_zero
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_NORM = 3'd1;
   localparam logic [2:0] ST_ADJ  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [TGT_W-1:0] den_ff, den_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [SIG_W-1:0] sig_ff, sig_in;
   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic [2:0]       k_ff, k_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             zero_ff, zero_in;
   logic             vld_ff, vld_in;
   logic [63:0]      res_ff, res_in;
   logic             wz_ff, wz_in;

   logic [TGT_W-1:0] tgt_dec;
   logic [7:0]       cexp;
   logic [7:0]       cshift;
   logic [22:0]      cman;
   logic [SH_W:0]    amt;
   logic [TGT_W-1:0] top_mask;
   logic [REM_W-1:0] step_rem;
   cmp_type          cmp;
   logic [REM_W-1:0] step_next;
   logic             rnd_up;
   logic [SIG_W:0]   sig_rnd;

   tdd_div_step u_step (
      .rem      (step_rem),
      .den      (den_ff),
      .cmp      (cmp),
      .rem_next (step_next)
   );

   assign busy = (state_ff != ST_IDLE);

   // target decode: word form or compact form
   always_comb begin
      cexp   = req_compact_bits[31:24];
      cman   = req_compact_bits[22:0];
      cshift = cexp - 8'd3;
      tgt_dec = '0;
      if (!req_cmd) begin
         tgt_dec = {req_target_word_3, req_target_word_2,
                    req_target_word_1, req_target_word_0};
      end else if (cexp <= 8'd3) begin
         tgt_dec = {233'b0, cman >> {(2'd3 - cexp[1:0]), 3'b0}};
      end else if (cshift < 8'd32) begin
         tgt_dec = {233'b0, cman} << {cshift[4:0], 3'b0};
      end
   end

   // normalization step: shift left by 2^k when the top 2^k bits are zero
   always_comb begin
      amt      = (SH_W+1)'(1) << k_ff;
      top_mask = ~({TGT_W{1'b1}} >> amt);
   end

   assign step_rem = (state_ff == ST_ADJ) ? {1'b0, NUM_NORM} : rem_ff;

   // round to nearest even from the doubled remainder
   always_comb begin
      rnd_up  = (cmp.ge && !cmp.eq) || (cmp.eq && sig_ff[0]);
      sig_rnd = {1'b0, sig_ff} + {{SIG_W{1'b0}}, rnd_up};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      sig_in   = sig_ff;
      sh_in    = sh_ff;
      exp_in   = exp_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      zero_in  = zero_ff;
      vld_in   = 1'b0;
      res_in   = res_ff;
      wz_in    = wz_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               den_in   = tgt_dec;
               zero_in  = (tgt_dec == '0);
               sh_in    = '0;
               k_in     = 3'd7;
               state_in = (tgt_dec == '0) ? ST_FIN : ST_NORM;
            end
         end
         ST_NORM: begin
            if ((den_ff & top_mask) == '0) begin
               den_in = den_ff << amt;
               sh_in  = sh_ff + amt[SH_W-1:0];
            end
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            // numerator below divisor: quotient starts one place lower
            if (cmp.ge) begin
               rem_in = {1'b0, NUM_NORM};
               exp_in = EXP_BASE + {3'b0, sh_ff};
            end else begin
               rem_in = {NUM_NORM, 1'b0};
               exp_in = EXP_BASE + {3'b0, sh_ff} - 11'd1;
            end
            sig_in   = '0;
            cnt_in   = 6'(SIG_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = step_next;
            sig_in = {sig_ff[SIG_W-2:0], cmp.ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            vld_in = 1'b1;
            wz_in  = zero_ff;
            if (zero_ff) begin
               res_in = DBL_INF;
            end else begin
               res_in = {1'b0, exp_ff, {FRAC_W{1'b0}}} + {{(63-SIG_W){1'b0}}, sig_rnd};
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      sig_ff  <= sig_in;
      sh_ff   <= sh_in;
      exp_ff  <= exp_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      res_ff  <= res_in;
      wz_ff   <= wz_in;
   end

   assign rsp_valid           = vld_ff;
   assign rsp_difficulty_bits = res_ff;
   assign rsp_target_was_zero = wz_ff;

   // checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("result strobe while sequencer busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_zero_inf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_target_was_zero) |-> (rsp_difficulty_bits == DBL_INF))
      else $error("zero target without infinity");

   a_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_target_was_zero) |->
         (rsp_difficulty_bits[62:52] != 11'h7ff && rsp_difficulty_bits[62:52] != 11'h000))
      else $error("nonzero target gave a non-normal result");
endmodule
